// ===== hw/rtl/rlgbd_pkg.sv =====
// package: beat types, register indexes and the rounded scale-by-255 helper
`timescale 1ns / 1ps

package rlgbd_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned PIPE_DEPTH = 3;

  localparam logic [CHAN_W-1:0] ROUND_HALF = 8'd127;
  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_RED_GAIN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GREEN_GAIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLUE_GAIN  = 2'd2;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    chan_t intensity;
  } in_item_t;

  typedef struct packed {
    chan_t red_duty;
    chan_t green_duty;
    chan_t blue_duty;
  } out_item_t;

  // one value per led channel
  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  // what moves from one pipeline stage to the next
  typedef struct packed {
    logic  valid;
    rgb_t  ch;
    chan_t level;
  } stage_t;

  // (a*b + 127) / 255, division done as (x + (x >> 8) + 1) >> 8, exact for x < 65535
  function automatic chan_t mul_div255(input chan_t a, input chan_t b);
    logic [2*CHAN_W-1:0] prod;
    logic [2*CHAN_W:0]   x;
    logic [2*CHAN_W:0]   q;
    prod = {{CHAN_W{1'b0}}, a} * {{CHAN_W{1'b0}}, b};
    x    = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, ROUND_HALF};
    q    = x + {{CHAN_W{1'b0}}, x[2*CHAN_W:CHAN_W]} + {{(2*CHAN_W){1'b0}}, 1'b1};
    return q[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// ===== hw/rtl/rlgbd_scale.sv =====
// one pipeline stage: three lanes of rounded multiply-and-divide-by-255
`timescale 1ns / 1ps

module rlgbd_scale
  import rlgbd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  stage_t stg_i,
  input  rgb_t   mult_i,
  output stage_t stg_o
);

  stage_t stg_r;
  stage_t stg_nxt;

  always_comb begin
    stg_nxt.valid = stg_i.valid;
    stg_nxt.level = stg_i.level;
    stg_nxt.ch.r  = mul_div255(stg_i.ch.r, mult_i.r);
    stg_nxt.ch.g  = mul_div255(stg_i.ch.g, mult_i.g);
    stg_nxt.ch.b  = mul_div255(stg_i.ch.b, mult_i.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else begin
      stg_r.valid <= stg_nxt.valid;
    end
    stg_r.ch    <= stg_nxt.ch;
    stg_r.level <= stg_nxt.level;
  end

  assign stg_o = stg_r;

endmodule

// ===== hw/rtl/rgb_led_gamma_balance_dim.sv =====
// top level: led gamma, white balance and dimming pipeline with gain registers
`timescale 1ns / 1ps

// Turns one sRGB colour and an intensity into three 8-bit LED PWM duty values.
// Per channel: gamma-2 linearization (c*c/255), white-balance gain (x*gain/255)
// and dimming (x*intensity/255), each division rounded to nearest.
// A colour beat is taken whenever start is high and busy is low; busy is high
// only during reset and up to the first clock edge after it, so a new colour
// can enter every cycle. Each multiply stage registers its result, and every
// accepted beat comes out once on out_data with out_valid high for one cycle.
// The receiver cannot hold results off, so it must take each beat as it comes.
// Gains reset to 255 (unity); cfg_we/cfg_addr/cfg_wdata write them, index 3 is
// ignored. The user must write them only while no beat is in flight (unenforced).

module rgb_led_gamma_balance_dim
  import rlgbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // colour input
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  // duty output, one cycle strobe
  output logic                  out_valid,
  output out_item_t             out_data,
  // gain registers
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  chan_t                 cfg_wdata
);

  logic   busy_r;
  rgb_t   gain_r;
  stage_t stg0;
  stage_t stg1;
  stage_t stg2;
  stage_t stg3;
  rgb_t   srgb;
  rgb_t   level_mult;

  // held busy through reset so no beat is taken while the pipeline clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // white-balance gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '{r: FULL_SCALE, g: FULL_SCALE, b: FULL_SCALE};
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RED_GAIN:   gain_r.r <= cfg_wdata;
        CFG_GREEN_GAIN: gain_r.g <= cfg_wdata;
        CFG_BLUE_GAIN:  gain_r.b <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage input: the colour, with intensity riding along for the last stage
  assign srgb       = '{r: in_data.red_in, g: in_data.green_in, b: in_data.blue_in};
  assign stg0.valid = start && !busy_r;
  assign stg0.ch    = srgb;
  assign stg0.level = in_data.intensity;

  // stage 1: gamma-2, each channel times itself
  rlgbd_scale u_gamma (
    .clk    (clk),
    .rst_n  (rst_n),
    .stg_i  (stg0),
    .mult_i (srgb),
    .stg_o  (stg1)
  );

  // stage 2: white balance; the user must write gains only while idle, the block does not enforce it
  rlgbd_scale u_balance (
    .clk    (clk),
    .rst_n  (rst_n),
    .stg_i  (stg1),
    .mult_i (gain_r),
    .stg_o  (stg2)
  );

  // stage 3: dimming by the intensity that traveled with the beat
  assign level_mult = '{r: stg2.level, g: stg2.level, b: stg2.level};

  rlgbd_scale u_dim (
    .clk    (clk),
    .rst_n  (rst_n),
    .stg_i  (stg2),
    .mult_i (level_mult),
    .stg_o  (stg3)
  );

  assign out_valid           = stg3.valid;
  assign out_data.red_duty   = stg3.ch.r;
  assign out_data.green_duty = stg3.ch.g;
  assign out_data.blue_duty  = stg3.ch.b;

endmodule

// ===== hw/rtl/rlgbd_checker.sv =====
// port checker for the led gamma pipeline, bound to the top level
`timescale 1ns / 1ps

module rlgbd_checker
  import rlgbd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_item_t              in_data,
  input logic                  out_valid,
  input out_item_t             out_data
);

  // every accepted beat comes out on out_valid
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted beat did not come out after three cycles");

  // no result without a matching accepted beat
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobe without a matching accepted beat");

  // zero intensity always dims to black
  a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.intensity == '0) |-> ##3 (out_data == '0))
    else $error("zero intensity gave a nonzero duty");

  // black input stays black whatever the gains
  a_black_in: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.red_in == '0 && in_data.green_in == '0
     && in_data.blue_in == '0) |-> ##3 (out_data == '0))
    else $error("black input gave a nonzero duty");

endmodule

bind rgb_led_gamma_balance_dim rlgbd_checker u_rlgbd_checker (.*);

// ===== test/tb_rgb_led_gamma_balance_dim.sv =====
// testbench: rgb_led_gamma_balance_dim driven with random colours, checked by a duty scoreboard
`timescale 1ns / 1ps

module tb_rgb_led_gamma_balance_dim;
  import rlgbd_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BEATS = 80;
  // index 3 is not a register, writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

  // predicts the three duty values per colour and holds them until they come out
  class duty_scoreboard;
    chan_t       gain [3];
    out_item_t   duty_q [$];
    int unsigned colours;
    int unsigned duties;
    int unsigned mismatches;

    function new();
      gain       = '{FULL_SCALE, FULL_SCALE, FULL_SCALE};
      colours    = 0;
      duties     = 0;
      mismatches = 0;
    endfunction

    function void write_gain(logic [CFG_ADDR_W-1:0] idx, chan_t value);
      if (idx <= CFG_BLUE_GAIN) begin
        gain[idx] = value;
      end
    endfunction

    // rounded a*b/255
    function chan_t scale255(chan_t a, chan_t b);
      int unsigned prod;
      prod = int'(a) * int'(b) + int'(ROUND_HALF);
      return chan_t'(prod / int'(FULL_SCALE));
    endfunction

    // gamma, then white balance, then dimming
    function chan_t duty_of(chan_t srgb, chan_t g, chan_t level);
      chan_t lin;
      chan_t bal;
      lin = scale255(srgb, srgb);
      bal = scale255(lin, g);
      return scale255(bal, level);
    endfunction

    function void note_colour(in_item_t c);
      out_item_t d;
      d.red_duty   = duty_of(c.red_in,   gain[CFG_RED_GAIN],   c.intensity);
      d.green_duty = duty_of(c.green_in, gain[CFG_GREEN_GAIN], c.intensity);
      d.blue_duty  = duty_of(c.blue_in,  gain[CFG_BLUE_GAIN],  c.intensity);
      duty_q.push_back(d);
      colours++;
    endfunction

    function void compare_field(string name, chan_t want, chan_t got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_duty(out_item_t got);
      out_item_t want;
      duties++;
      if (duty_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected duty beat, expected none, got %h", $time, got);
      end else begin
        want = duty_q.pop_front();
        compare_field("red_duty",   want.red_duty,   got.red_duty);
        compare_field("green_duty", want.green_duty, got.green_duty);
        compare_field("blue_duty",  want.blue_duty,  got.blue_duty);
      end
    endfunction

    function int unsigned pending();
      return duty_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  chan_t                 cfg_wdata = '0;

  duty_scoreboard board = new();
  int unsigned    cycle_count = 0;
  int unsigned    gain_writes = 0;

  rgb_led_gamma_balance_dim i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // watchdog: a correct run finishes far below this
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d duty beats still expected", $time, board.pending());
      $display("** rgb_led_gamma_balance_dim: FAILED **");
      $finish;
    end
  end

  // one monitor for everything that happens at an edge, so the order is fixed:
  // register writes first, then accepted colours, then duty beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        board.write_gain(cfg_addr, cfg_wdata);
      end
      if (start && !busy) begin
        board.note_colour(in_data);
      end
      if (out_valid !== 1'b0) begin
        board.check_duty(out_data);
      end
    end
  end

  // half the time the extremes and their neighbors, otherwise anything
  function automatic chan_t pick_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FULL_SCALE;
      2:       return chan_t'($urandom_range(1, 3));
      3:       return chan_t'($urandom_range(252, 254));
      default: return chan_t'($urandom);
    endcase
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  // present one colour beat and hold it until the block takes it
  task automatic send_colour(chan_t r, chan_t g, chan_t b, chan_t level);
    start   <= 1'b1;
    in_data <= '{red_in: r, green_in: g, blue_in: b, intensity: level};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // start low for a while, with junk on the data lines that must be ignored
  task automatic idle_for(int unsigned cycles);
    start   <= 1'b0;
    in_data <= in_item_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every predicted beat has come out, then let the pipe settle
  task automatic wait_drained();
    idle_for(1);
    while (board.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // leaves cfg_we high, the caller lowers it after the last write
  task automatic write_gain_reg(logic [CFG_ADDR_W-1:0] idx, chan_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    gain_writes++;
    @(posedge clk);
  endtask

  task automatic apply_gains(chan_t r, chan_t g, chan_t b);
    write_gain_reg(CFG_RED_GAIN, r);
    write_gain_reg(CFG_GREEN_GAIN, g);
    write_gain_reg(CFG_BLUE_GAIN, b);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed colours at the reset gains (unity); the first one meets busy
    send_colour(8'd0,   8'd0,   8'd0,   8'd0);
    send_colour(8'd255, 8'd255, 8'd255, 8'd255);
    send_colour(8'd255, 8'd255, 8'd255, 8'd0);
    send_colour(8'd0,   8'd0,   8'd0,   8'd255);
    send_colour(8'd1,   8'd1,   8'd1,   8'd255);
    send_colour(8'd255, 8'd128, 8'd1,   8'd255);
    send_colour(8'd128, 8'd127, 8'd255, 8'd128);
    send_colour(8'd16,  8'd32,  8'd64,  8'd1);
    send_colour(8'd254, 8'd253, 8'd2,   8'd254);
    send_colour(8'd255, 8'd0,   8'd255, 8'd255);
    send_colour(8'd170, 8'd85,  8'd15,  8'd240);
    send_colour(8'd11,  8'd12,  8'd23,  8'd255);
    wait_drained();

    // a write to the spare index must leave all three gains at unity
    write_gain_reg(CFG_SPARE, 8'd0);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_colour(8'd255, 8'd255, 8'd255, 8'd255);
    send_colour(8'd200, 8'd100, 8'd50,  8'd255);
    wait_drained();

    // zero and minimal gains kill or nearly kill every channel
    apply_gains(8'd0, 8'd0, 8'd0);
    send_colour(8'd255, 8'd255, 8'd255, 8'd255);
    send_colour(8'd128, 8'd64,  8'd1,   8'd200);
    wait_drained();
    apply_gains(8'd1, 8'd1, 8'd1);
    send_colour(8'd255, 8'd255, 8'd255, 8'd255);
    send_colour(8'd254, 8'd200, 8'd100, 8'd254);
    wait_drained();

    // random colours, one gain setting per phase
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       apply_gains(FULL_SCALE, FULL_SCALE, FULL_SCALE);
        1:       apply_gains(8'd255, 8'd0, 8'd128);
        2:       apply_gains(8'd0, 8'd255, 8'd1);
        3:       apply_gains(8'd254, 8'd127, 8'd255);
        default: apply_gains(pick_chan(), pick_chan(), pick_chan());
      endcase
      for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
        send_colour(pick_chan(), pick_chan(), pick_chan(), pick_chan());
        if (phase == 2 && n == PHASE_BEATS / 2) begin
          // hold off until the pipe has emptied, mid-phase
          wait_drained();
        end else if (n < 20 || n >= 40) begin
          // beats 20..39 of each phase run back to back
          if (pick_gap() != 0) begin
            idle_for(pick_gap() + 1);
          end
        end
      end
      wait_drained();
    end

    $display("covered %0d colour beats and %0d duty beats over %0d gain register writes",
             board.colours, board.duties, gain_writes);
    $display("gains swept through 0, 1, 254, 255 and random values, plus a spare-index write");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** rgb_led_gamma_balance_dim: PASSED **");
    end else begin
      $display("%0d mismatches, %0d duty beats never seen", board.mismatches, board.pending());
      $display("** rgb_led_gamma_balance_dim: FAILED **");
    end
    $finish;
  end

endmodule
